[rtl/core/dmsef_pkg.sv]
// Shared types, constants and arithmetic helpers for the DM site energy/field block.
package dmsef_pkg;

	// Default geometry
	localparam int SITES_DEF          = 1024;
	localparam int MAX_NEIGHBORS_DEF  = 16;
	localparam int COMPONENT_BITS_DEF = 16;

	// Stored vector component width (Q1.14 in a 16-bit signed word)
	localparam int VEC_W  = 16;
	// Cross-product component width (difference of two Q.28 products)
	localparam int CROSS_W = 2 * VEC_W + 1;
	// Accumulator widths, sized for up to 32 neighbor slots
	localparam int ESUM_W = 56;
	localparam int FSUM_W = 40;
	// Split point of the energy sum for the final scaling
	localparam int ESPLIT = 26;
	// Neighbor table entry: present flag and neighbor site
	localparam int NB_W   = 10;
	localparam int TAB_W  = NB_W + 1;

	// Commands
	typedef enum logic [1:0] {
		CMD_SPIN  = 2'd0,
		CMD_NB    = 2'd1,
		CMD_QUERY = 2'd2
	} cmd_t;

	// Configuration register indexes
	localparam logic REG_ENERGY = 1'b0;
	localparam logic REG_NIU    = 1'b1;

	typedef logic signed [VEC_W-1:0] comp_t;

	typedef struct packed {
		comp_t x;
		comp_t y;
		comp_t z;
	} vec_t;

	typedef struct packed {
		logic signed [CROSS_W-1:0] x;
		logic signed [CROSS_W-1:0] y;
		logic signed [CROSS_W-1:0] z;
	} xvec_t;

	// Classified command waiting in the queue
	typedef struct packed {
		cmd_t           cmd;
		logic           site_ok;
		logic [9:0]     site;
		logic [3:0]     slot;
		logic [NB_W-1:0] nb;
		logic           present;
		vec_t           v;
	} item_t;

	// Queue head as seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	typedef struct packed {
		logic [31:0] value;
		logic        clipped;
	} sat_t;

	// a x b with exact products
	function automatic xvec_t cross3(input vec_t a, input vec_t b);
		xvec_t r;
		r.x = CROSS_W'(a.y * b.z) - CROSS_W'(a.z * b.y);
		r.y = CROSS_W'(a.z * b.x) - CROSS_W'(a.x * b.z);
		r.z = CROSS_W'(a.x * b.y) - CROSS_W'(a.y * b.x);
		return r;
	endfunction

	// Clip a signed value to the signed 32-bit range
	function automatic sat_t sat32(input logic signed [63:0] v);
		sat_t r;
		if (v > 64'sd2147483647) begin
			r.value   = 32'h7FFF_FFFF;
			r.clipped = 1'b1;
		end else if (v < -64'sd2147483648) begin
			r.value   = 32'h8000_0000;
			r.clipped = 1'b1;
		end else begin
			r.value   = v[31:0];
			r.clipped = 1'b0;
		end
		return r;
	endfunction

endpackage

[rtl/core/dm_site_energy_field.sv]
// Top level of the DM site energy and effective field block.
//
// Command channel: an item is taken at a clock edge with start high and busy
// low. Command 0 writes a site spin, 1 writes a neighbor slot (present flag,
// neighbor site, DM vector), 2 queries one site; command 3 and out-of-range
// writes are dropped. Vector components are clipped to 16-bit Q1.14.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index 0 = energy_param
// (J, Q8.8), 1 = neighbors_in_use; cfg_ready is always high.
// Results: a query gives one transaction marked by done for a single cycle;
// the receiver cannot stall, so results are never held.
// Timing: a write is applied to its memory as it leaves the queue. A query
// walks the slots in use once it leaves the queue; the walk issues one
// neighbor table read per cycle and runs a four-stage product pipeline,
// then the ST_MUL and ST_FIN states of scaling and rounding. A two-entry
// queue lets new commands arrive while a query runs.
// Reset: the neighbor table is swept to absent, and busy stays high during
// the sweep.
module dm_site_energy_field #(
	parameter int SITES          = dmsef_pkg::SITES_DEF,
	parameter int MAX_NEIGHBORS  = dmsef_pkg::MAX_NEIGHBORS_DEF,
	parameter int COMPONENT_BITS = dmsef_pkg::COMPONENT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       command,
	input  logic [9:0]                       site,
	input  logic [3:0]                       slot,
	input  logic [9:0]                       neighbor_site,
	input  logic                             neighbor_present,
	input  logic signed [COMPONENT_BITS-1:0] vec_x,
	input  logic signed [COMPONENT_BITS-1:0] vec_y,
	input  logic signed [COMPONENT_BITS-1:0] vec_z,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_index,
	input  logic [15:0]                      cfg_data,
	output logic                             done,
	output logic signed [31:0]               energy,
	output logic signed [31:0]               field_x,
	output logic signed [31:0]               field_y,
	output logic signed [31:0]               field_z,
	output logic                             saturated
);

	dmsef_pkg::head_t   head;
	logic               pop, full, clearing;
	logic signed [15:0] energy_param_q;
	logic [4:0]         niu_q;

	assign busy      = full || clearing;
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_param_q <= '0;
			niu_q          <= 5'd6;
		end else if (cfg_valid) begin
			case (cfg_index)
				dmsef_pkg::REG_ENERGY: energy_param_q <= cfg_data;
				dmsef_pkg::REG_NIU:    niu_q          <= cfg_data[4:0];
				default:               niu_q          <= niu_q;
			endcase
		end
	end

	dmsef_front #(
		.SITES(SITES), .MAX_NEIGHBORS(MAX_NEIGHBORS), .COMPONENT_BITS(COMPONENT_BITS)
	) u_front (
		.clk(clk), .arst_n(arst_n), .accept(start && !busy),
		.command(command), .site(site), .slot(slot),
		.neighbor_site(neighbor_site), .neighbor_present(neighbor_present),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.pop(pop), .full(full), .head(head)
	);

	dmsef_back #(
		.SITES(SITES), .MAX_NEIGHBORS(MAX_NEIGHBORS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .head(head),
		.energy_param(energy_param_q), .neighbors_in_use(niu_q),
		.pop(pop), .clearing(clearing), .done(done),
		.energy(energy), .field_x(field_x), .field_y(field_y), .field_z(field_z),
		.saturated(saturated)
	);

endmodule

[rtl/core/dmsef_ram.sv]
// Generic simple dual-port RAM with registered read.
module dmsef_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/dmsef_front.sv]
// Front end: accepts commands, classifies them and queues them for the back end.
module dmsef_front #(
	parameter int SITES          = dmsef_pkg::SITES_DEF,
	parameter int MAX_NEIGHBORS  = dmsef_pkg::MAX_NEIGHBORS_DEF,
	parameter int COMPONENT_BITS = dmsef_pkg::COMPONENT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  logic [1:0]                       command,
	input  logic [9:0]                       site,
	input  logic [3:0]                       slot,
	input  logic [9:0]                       neighbor_site,
	input  logic                             neighbor_present,
	input  logic signed [COMPONENT_BITS-1:0] vec_x,
	input  logic signed [COMPONENT_BITS-1:0] vec_y,
	input  logic signed [COMPONENT_BITS-1:0] vec_z,
	input  logic                             pop,
	output logic                             full,
	output dmsef_pkg::head_t                 head
);

	localparam int EW = (COMPONENT_BITS > dmsef_pkg::VEC_W) ? COMPONENT_BITS
	                                                        : dmsef_pkg::VEC_W;

	// Sign-extend and clip one component to 16 bits
	function automatic dmsef_pkg::comp_t comp_in(input logic signed [COMPONENT_BITS-1:0] v);
		logic signed [EW-1:0] e;
		e = EW'(v);
		if (e > EW'(32767)) begin
			return dmsef_pkg::comp_t'(16'sh7FFF);
		end else if (e < -EW'(32768)) begin
			return dmsef_pkg::comp_t'(16'sh8000);
		end
		return e[dmsef_pkg::VEC_W-1:0];
	endfunction

	dmsef_pkg::item_t item_c;
	logic             keep_c;
	logic             site_ok_c;

	// Classification: drop unknown commands and out-of-range writes
	always_comb begin
		site_ok_c        = 32'(site) < SITES;
		item_c.cmd       = dmsef_pkg::cmd_t'(command);
		item_c.site_ok   = site_ok_c;
		item_c.site      = site;
		item_c.slot      = slot;
		item_c.nb        = neighbor_site;
		item_c.present   = neighbor_present;
		item_c.v.x       = comp_in(vec_x);
		item_c.v.y       = comp_in(vec_y);
		item_c.v.z       = comp_in(vec_z);
		case (item_c.cmd)
			dmsef_pkg::CMD_SPIN:  keep_c = site_ok_c;
			dmsef_pkg::CMD_NB:    keep_c = site_ok_c && (32'(slot) < MAX_NEIGHBORS)
			                               && (32'(neighbor_site) < SITES);
			dmsef_pkg::CMD_QUERY: keep_c = 1'b1;
			default:              keep_c = 1'b0;
		endcase
	end

	// Two-entry queue
	dmsef_pkg::item_t q0_q, q1_q;
	logic             v0_q, v1_q;
	logic             push;

	assign push = accept && keep_c;
	assign full = v1_q;
	assign head.valid = v0_q;
	assign head.item  = q0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else begin
			if (pop) begin
				v0_q <= v1_q || push;
				v1_q <= v1_q && push;
			end else if (push) begin
				v0_q <= 1'b1;
				v1_q <= v0_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (v1_q) begin
				q0_q <= q1_q;
			end else begin
				q0_q <= item_c;
			end
			q1_q <= item_c;
		end else if (push) begin
			if (v0_q) begin
				q1_q <= item_c;
			end else begin
				q0_q <= item_c;
			end
		end
	end

endmodule

[rtl/core/dmsef_back.sv]
// Back end: store writes, table clearing pass and the per-site neighbor walk.
module dmsef_back #(
	parameter int SITES          = dmsef_pkg::SITES_DEF,
	parameter int MAX_NEIGHBORS  = dmsef_pkg::MAX_NEIGHBORS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dmsef_pkg::head_t        head,
	input  logic signed [15:0]      energy_param,
	input  logic [4:0]              neighbors_in_use,
	output logic                    pop,
	output logic                    clearing,
	output logic                    done,
	output logic signed [31:0]      energy,
	output logic signed [31:0]      field_x,
	output logic signed [31:0]      field_y,
	output logic signed [31:0]      field_z,
	output logic                    saturated
);

	localparam int DEPTH = SITES * MAX_NEIGHBORS;
	localparam int AW    = $clog2(DEPTH);
	localparam int SAW   = $clog2(SITES);
	localparam int NW    = $clog2(MAX_NEIGHBORS + 1);
	localparam int VW3   = 3 * dmsef_pkg::VEC_W;
	localparam int CW    = dmsef_pkg::CROSS_W;
	localparam int PW    = CW + dmsef_pkg::VEC_W;
	localparam int EW    = dmsef_pkg::ESUM_W;
	localparam int FW    = dmsef_pkg::FSUM_W;
	localparam int HW    = EW - dmsef_pkg::ESPLIT;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_MUL,
		ST_FIN
	} state_t;

	state_t state_q;

	dmsef_pkg::item_t it;
	assign it = head.item;

	// Memories
	logic                          spin_we, tab_we;
	logic [SAW-1:0]                spin_waddr, spin_raddr;
	logic [VW3-1:0]                spin_rdata, dm_rdata;
	logic [AW-1:0]                 tab_waddr, tab_raddr;
	logic [dmsef_pkg::TAB_W-1:0]   tab_wdata, tab_rdata;
	logic                          dm_we;

	dmsef_ram #(.WIDTH(VW3), .DEPTH(SITES)) u_spin (
		.clk(clk), .we(spin_we), .waddr(spin_waddr), .wdata(it.v),
		.raddr(spin_raddr), .rdata(spin_rdata)
	);

	dmsef_ram #(.WIDTH(dmsef_pkg::TAB_W), .DEPTH(DEPTH)) u_tab (
		.clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
		.raddr(tab_raddr), .rdata(tab_rdata)
	);

	dmsef_ram #(.WIDTH(VW3), .DEPTH(DEPTH)) u_dm (
		.clk(clk), .we(dm_we), .waddr(tab_waddr), .wdata(it.v),
		.raddr(tab_raddr), .rdata(dm_rdata)
	);

	// Walk control
	logic [AW-1:0]  clr_q;
	logic [AW-1:0]  base_q;
	logic [NW-1:0]  idx_q, count_q;
	logic           issue;
	logic           start_q;
	logic           v_s1, v_s2, v_s3, v_s4;
	logic [NW-1:0]  count_c;
	logic [AW-1:0]  slot_addr;

	assign count_c  = (32'(neighbors_in_use) > MAX_NEIGHBORS) ? NW'(MAX_NEIGHBORS)
	                                                          : NW'(neighbors_in_use);
	assign slot_addr = AW'(32'(it.site) * MAX_NEIGHBORS + 32'(it.slot));
	assign issue     = (state_q == ST_WALK) && (idx_q != count_q);
	assign pop       = (state_q == ST_IDLE) && head.valid;
	assign clearing  = (state_q == ST_CLEAR);

	// Memory port steering
	always_comb begin
		spin_we    = pop && (it.cmd == dmsef_pkg::CMD_SPIN);
		spin_waddr = SAW'(it.site);
		tab_we     = pop && (it.cmd == dmsef_pkg::CMD_NB);
		dm_we      = tab_we;
		tab_waddr  = slot_addr;
		tab_wdata  = {it.present, it.nb};
		if (state_q == ST_CLEAR) begin
			tab_we    = 1'b1;
			tab_waddr = clr_q;
			tab_wdata = '0;
		end
		tab_raddr = base_q + AW'(idx_q);
		if (v_s1) begin
			spin_raddr = SAW'(tab_rdata[dmsef_pkg::NB_W-1:0]);
		end else begin
			spin_raddr = SAW'(it.site);
		end
	end

	// Datapath pipeline
	dmsef_pkg::vec_t  s_site_q, dm_s2, dm_s3, sn;
	dmsef_pkg::xvec_t c_s3, f_s3, f_s4;
	logic signed [PW-1:0] e0_s4, e1_s4, e2_s4;
	logic signed [EW-1:0] esum_q;
	logic signed [FW-1:0] fx_q, fy_q, fz_q;

	assign sn = spin_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1 && tab_rdata[dmsef_pkg::NB_W];
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (start_q) begin
			s_site_q <= spin_rdata;
		end
		dm_s2 <= dm_rdata;
		// site spin x neighbor spin, DM x neighbor spin
		c_s3  <= dmsef_pkg::cross3(s_site_q, sn);
		f_s3  <= dmsef_pkg::cross3(dm_s2, sn);
		dm_s3 <= dm_s2;
		// DM . (S_site x S_nb) terms
		e0_s4 <= PW'(dm_s3.x * c_s3.x);
		e1_s4 <= PW'(dm_s3.y * c_s3.y);
		e2_s4 <= PW'(dm_s3.z * c_s3.z);
		f_s4  <= f_s3;
	end

	// Final scaling registers
	logic signed [16:0]       p;
	logic signed [HW+16:0]    pe_h;
	logic signed [dmsef_pkg::ESPLIT+17:0] pe_l;
	logic signed [FW+16:0]    pfx, pfy, pfz;
	logic signed [EW+20:0]    etot;
	dmsef_pkg::sat_t          se, sx, sy, sz;

	assign p = -17'(energy_param);

	always_comb begin
		etot = ((EW+21)'(pe_h) <<< dmsef_pkg::ESPLIT) + (EW+21)'(pe_l)
		       + ((EW+21)'(1) <<< 33);
		se = dmsef_pkg::sat32(64'(etot >>> 34));
		sx = dmsef_pkg::sat32(64'((pfx + (FW+17)'(1 <<< 19)) >>> 20));
		sy = dmsef_pkg::sat32(64'((pfy + (FW+17)'(1 <<< 19)) >>> 20));
		sz = dmsef_pkg::sat32(64'((pfz + (FW+17)'(1 <<< 19)) >>> 20));
	end

	// Sequencer, accumulators and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			base_q    <= '0;
			idx_q     <= '0;
			count_q   <= '0;
			start_q   <= 1'b0;
			done      <= 1'b0;
			esum_q    <= '0;
			fx_q      <= '0;
			fy_q      <= '0;
			fz_q      <= '0;
			pe_h      <= '0;
			pe_l      <= '0;
			pfx       <= '0;
			pfy       <= '0;
			pfz       <= '0;
			energy    <= '0;
			field_x   <= '0;
			field_y   <= '0;
			field_z   <= '0;
			saturated <= 1'b0;
		end else begin
			done    <= 1'b0;
			start_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (32'(clr_q) == DEPTH - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop && it.cmd == dmsef_pkg::CMD_QUERY) begin
						esum_q  <= '0;
						fx_q    <= '0;
						fy_q    <= '0;
						fz_q    <= '0;
						base_q  <= AW'(32'(it.site) * MAX_NEIGHBORS);
						idx_q   <= '0;
						count_q <= it.site_ok ? count_c : '0;
						start_q <= 1'b1;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (issue) begin
						idx_q <= idx_q + NW'(1);
					end
					if (v_s4) begin
						esum_q <= esum_q + EW'(e0_s4) + EW'(e1_s4) + EW'(e2_s4);
						fx_q   <= fx_q + FW'(f_s4.x);
						fy_q   <= fy_q + FW'(f_s4.y);
						fz_q   <= fz_q + FW'(f_s4.z);
					end
					if (!issue && !v_s1 && !v_s2 && !v_s3 && !v_s4 && !start_q) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					pe_h    <= (HW+17)'(p * $signed(esum_q[EW-1:dmsef_pkg::ESPLIT]));
					pe_l    <= (dmsef_pkg::ESPLIT+18)'(p * $signed({1'b0,
					           esum_q[dmsef_pkg::ESPLIT-1:0]}));
					pfx     <= (FW+17)'(p * fx_q);
					pfy     <= (FW+17)'(p * fy_q);
					pfz     <= (FW+17)'(p * fz_q);
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					energy    <= se.value;
					field_x   <= sx.value;
					field_y   <= sy.value;
					field_z   <= sz.value;
					saturated <= se.clipped | sx.clipped | sy.clipped | sz.clipped;
					done      <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[tb/sv/tb_dm_site_energy_field.sv]
// Self-checking testbench for the DM site energy and effective field block.
`timescale 1ns / 1ps

module tb_dm_site_energy_field;

	localparam logic [1:0] CMD_NONE = 2'd3;  // unknown command, dropped by the block
	localparam int NSITES = 1024;
	localparam int NSLOTS = 16;
	localparam int SETTLE = 60;

	typedef struct {
		logic signed [31:0] en;
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		logic signed [31:0] fz;
		logic               sat;
	} site_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [1:0]          command = '0;
	logic [9:0]          site = '0;
	logic [3:0]          slot = '0;
	logic [9:0]          neighbor_site = '0;
	logic                neighbor_present = 1'b0;
	logic signed [15:0]  vec_x = '0;
	logic signed [15:0]  vec_y = '0;
	logic signed [15:0]  vec_z = '0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic                cfg_index = dmsef_pkg::REG_ENERGY;
	logic [15:0]         cfg_data = '0;
	logic                done;
	logic signed [31:0]  energy, field_x, field_y, field_z;
	logic                saturated;

	dm_site_energy_field i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .site(site), .slot(slot), .neighbor_site(neighbor_site),
		.neighbor_present(neighbor_present), .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .energy(energy), .field_x(field_x),
		.field_y(field_y), .field_z(field_z), .saturated(saturated)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow copy of the block state
	dmsef_pkg::vec_t  spin_mem [NSITES];
	bit               spin_known [NSITES];
	bit               nb_pres [NSITES*NSLOTS];
	logic [9:0]       nb_idx [NSITES*NSLOTS];
	dmsef_pkg::vec_t  dm_mem [NSITES*NSLOTS];
	logic signed [15:0] j_reg;
	logic [4:0]       niu_reg;

	site_result_t     pending_results[$];
	int               errors = 0;
	bit               calm = 1'b0;

	function automatic logic signed [31:0] clip32(input logic signed [127:0] v,
			inout logic flag);
		if (v > 128'sd2147483647) begin
			flag = 1'b1;
			return 32'sh7FFF_FFFF;
		end
		if (v < -128'sd2147483648) begin
			flag = 1'b1;
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// Energy and field of one site from the shadow state
	function automatic site_result_t site_energy_field(input logic [9:0] s);
		site_result_t r;
		longint esum, fs[3], a[3], b[3], d[3], c[3];
		logic signed [127:0] pw, acc;
		int cnt, addr;
		logic flag;
		esum = 0;
		fs = '{0, 0, 0};
		flag = 1'b0;
		cnt = (niu_reg > NSLOTS) ? NSLOTS : niu_reg;
		a = '{spin_mem[s].x, spin_mem[s].y, spin_mem[s].z};
		for (int i = 0; i < cnt; i++) begin
			addr = s * NSLOTS + i;
			if (nb_pres[addr]) begin
				b = '{spin_mem[nb_idx[addr]].x, spin_mem[nb_idx[addr]].y,
					spin_mem[nb_idx[addr]].z};
				d = '{dm_mem[addr].x, dm_mem[addr].y, dm_mem[addr].z};
				c[0] = a[1]*b[2] - a[2]*b[1];
				c[1] = a[2]*b[0] - a[0]*b[2];
				c[2] = a[0]*b[1] - a[1]*b[0];
				esum += d[0]*c[0] + d[1]*c[1] + d[2]*c[2];
				fs[0] += d[1]*b[2] - d[2]*b[1];
				fs[1] += d[2]*b[0] - d[0]*b[2];
				fs[2] += d[0]*b[1] - d[1]*b[0];
			end
		end
		pw = -j_reg;
		acc = esum;
		acc = pw * acc + (128'sd1 <<< 33);
		r.en = clip32(acc >>> 34, flag);
		acc = fs[0];
		r.fx = clip32((pw * acc + (128'sd1 <<< 19)) >>> 20, flag);
		acc = fs[1];
		r.fy = clip32((pw * acc + (128'sd1 <<< 19)) >>> 20, flag);
		acc = fs[2];
		r.fz = clip32((pw * acc + (128'sd1 <<< 19)) >>> 20, flag);
		r.sat = flag;
		return r;
	endfunction

	// Apply one accepted transaction to the shadow state
	function automatic void track_command(input logic [1:0] c, input logic [9:0] s,
			input logic [3:0] sl, input logic [9:0] nb, input logic pr,
			input dmsef_pkg::vec_t v);
		int addr;
		addr = s * NSLOTS + sl;
		case (c)
			dmsef_pkg::CMD_SPIN: begin
				spin_mem[s] = v;
				spin_known[s] = 1'b1;
			end
			dmsef_pkg::CMD_NB: begin
				nb_pres[addr] = pr;
				nb_idx[addr] = nb;
				dm_mem[addr] = v;
			end
			dmsef_pkg::CMD_QUERY: pending_results.push_back(site_energy_field(s));
			default: ;
		endcase
	endfunction

	// Drive one command transaction and wait for it to be taken
	task automatic send_command(input logic [1:0] c, input logic [9:0] s,
			input logic [3:0] sl, input logic [9:0] nb, input logic pr,
			input dmsef_pkg::vec_t v);
		@(negedge clk);
		if (!calm && $urandom_range(99) < 27) begin
			start = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		command = c; site = s; slot = sl; neighbor_site = nb;
		neighbor_present = pr; vec_x = v.x; vec_y = v.y; vec_z = v.z;
		start = 1'b1;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		track_command(c, s, sl, nb, pr, v);
	endtask

	function automatic dmsef_pkg::comp_t rand_comp();
		case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return dmsef_pkg::comp_t'($urandom);
			default: return dmsef_pkg::comp_t'(int'($urandom_range(32768)) - 16384);
		endcase
	endfunction

	function automatic dmsef_pkg::vec_t rand_vec();
		dmsef_pkg::vec_t v;
		v.x = rand_comp();
		v.y = rand_comp();
		v.z = rand_comp();
		return v;
	endfunction

	// Spins are written before any present slot can refer to them
	task automatic write_spin_if_new(input logic [9:0] s);
		if (!spin_known[s]) send_command(dmsef_pkg::CMD_SPIN, s, '0, '0, 1'b0, rand_vec());
	endtask

	task automatic write_slot(input logic [9:0] s, input logic [3:0] sl,
			input logic [9:0] nb, input logic pr, input dmsef_pkg::vec_t v);
		if (pr) begin
			write_spin_if_new(s);
			write_spin_if_new(nb);
		end
		send_command(dmsef_pkg::CMD_NB, s, sl, nb, pr, v);
	endtask

	// Wait until all results arrived and the block has gone quiet
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [15:0] val);
		drain();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		if (idx == dmsef_pkg::REG_ENERGY) j_reg = val;
		else niu_reg = val[4:0];
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Result checker: each done cycle is one transaction
	always @(posedge clk) begin
		site_result_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (energy !== e.en) begin
					$error("energy expected %0d actual %0d", e.en, energy); errors++;
				end
				if (field_x !== e.fx) begin
					$error("field_x expected %0d actual %0d", e.fx, field_x); errors++;
				end
				if (field_y !== e.fy) begin
					$error("field_y expected %0d actual %0d", e.fy, field_y); errors++;
				end
				if (field_z !== e.fz) begin
					$error("field_z expected %0d actual %0d", e.fz, field_z); errors++;
				end
				if (saturated !== e.sat) begin
					$error("saturated expected %0d actual %0d", e.sat, saturated); errors++;
				end
			end
		end
	end

	// Query right after reset: every slot is absent; an unknown command follows
	task automatic test_reset_defaults();
		send_command(dmsef_pkg::CMD_QUERY, 10'd0, '0, '0, 1'b0, '0);
		send_command(dmsef_pkg::CMD_QUERY, 10'd1023, '0, '0, 1'b0, '0);
		send_command(CMD_NONE, 10'd5, 4'd3, 10'd7, 1'b1, rand_vec());
	endtask

	// Full-scale spins and DM vectors on all slots of one site, strongest J
	task automatic test_extremes();
		dmsef_pkg::vec_t vmax, vmin;
		vmax = '{16'sh7FFF, 16'sh8000, 16'sh7FFF};
		vmin = '{16'sh8000, 16'sh7FFF, 16'sh8000};
		write_register(dmsef_pkg::REG_ENERGY, 16'h8000);
		write_register(dmsef_pkg::REG_NIU, 16'd16);
		send_command(dmsef_pkg::CMD_SPIN, 10'd1023, '0, '0, 1'b0, vmax);
		send_command(dmsef_pkg::CMD_SPIN, 10'd0, '0, '0, 1'b0,
			'{16'sh8000, 16'sh8000, 16'sh7FFF});
		for (int i = 0; i < 16; i++)
			write_slot(10'd1023, 4'(i), 10'd0, 1'b1, (i % 2) ? vmin : vmax);
		write_slot(10'd0, 4'd15, 10'd1023, 1'b1, vmax);
		write_slot(10'd0, 4'd0, 10'd1023, 1'b0, vmin);
		send_command(dmsef_pkg::CMD_QUERY, 10'd1023, '0, '0, 1'b0, '0);
		send_command(dmsef_pkg::CMD_QUERY, 10'd0, '0, '0, 1'b0, '0);
		write_register(dmsef_pkg::REG_ENERGY, 16'h7FFF);
		send_command(dmsef_pkg::CMD_QUERY, 10'd1023, '0, '0, 1'b0, '0);
	endtask

	// Slot counts of zero, one and above the table depth
	task automatic test_slot_counts();
		write_register(dmsef_pkg::REG_NIU, 16'd0);
		send_command(dmsef_pkg::CMD_QUERY, 10'd1023, '0, '0, 1'b0, '0);
		write_register(dmsef_pkg::REG_NIU, 16'd31);
		send_command(dmsef_pkg::CMD_QUERY, 10'd1023, '0, '0, 1'b0, '0);
		write_register(dmsef_pkg::REG_NIU, 16'd1);
		send_command(dmsef_pkg::CMD_QUERY, 10'd1023, '0, '0, 1'b0, '0);
		write_register(dmsef_pkg::REG_ENERGY, 16'h0000);
		send_command(dmsef_pkg::CMD_QUERY, 10'd1023, '0, '0, 1'b0, '0);
	endtask

	// Random mix, mostly built around a small pool of sites
	task automatic test_random();
		logic [9:0] pool[8];
		logic [9:0] s, nb;
		int pick, nitems;
		foreach (pool[i]) pool[i] = 10'($urandom);
		nitems = 0;
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					write_register(dmsef_pkg::REG_ENERGY, 16'h0100);
					write_register(dmsef_pkg::REG_NIU, 16'd6);
				end
				1: begin
					write_register(dmsef_pkg::REG_ENERGY, 16'($urandom));
					write_register(dmsef_pkg::REG_NIU, 16'($urandom_range(1, 16)));
				end
				2: begin
					write_register(dmsef_pkg::REG_ENERGY, 16'h8000);
					write_register(dmsef_pkg::REG_NIU, 16'd16);
				end
				3: begin
					write_register(dmsef_pkg::REG_ENERGY, 16'h7FFF);
					write_register(dmsef_pkg::REG_NIU, 16'($urandom_range(0, 31)));
				end
				default: begin
					write_register(dmsef_pkg::REG_ENERGY, 16'($urandom));
					write_register(dmsef_pkg::REG_NIU, 16'd6);
				end
			endcase
			calm = (phase == 2);
			for (int k = 0; k < 100; k++) begin
				s = ($urandom_range(9) < 8) ? pool[$urandom_range(7)] : 10'($urandom);
				nb = ($urandom_range(9) < 7) ? pool[$urandom_range(7)] : 10'($urandom);
				pick = $urandom_range(99);
				if (pick < 20) send_command(dmsef_pkg::CMD_SPIN, s, 4'($urandom),
						10'($urandom), 1'($urandom), rand_vec());
				else if (pick < 62) write_slot(s, 4'($urandom), nb,
						$urandom_range(9) < 8, rand_vec());
				else if (pick < 95) send_command(dmsef_pkg::CMD_QUERY, s, 4'($urandom),
						10'($urandom), 1'($urandom), rand_vec());
				else send_command(CMD_NONE, s, 4'($urandom), nb, 1'($urandom), rand_vec());
				// hold off until the block has caught up
				if (k == 50 && phase == 1) drain();
			end
			calm = 1'b0;
		end
	endtask

	initial begin
		j_reg = '0;
		niu_reg = 5'd6;
		foreach (spin_known[i]) spin_known[i] = 1'b0;
		foreach (nb_pres[i]) nb_pres[i] = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_defaults();
		test_extremes();
		test_slot_counts();
		test_random();
		drain();
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

endmodule

[sim.f]
rtl/core/dmsef_pkg.sv
rtl/core/dmsef_ram.sv
rtl/core/dmsef_front.sv
rtl/core/dmsef_back.sv
rtl/core/dm_site_energy_field.sv
tb/sv/tb_dm_site_energy_field.sv
